/* src/cbc_pkg.sv */
package cbc_pkg;

    localparam int CELLS    = 6;
    localparam int CELL_W   = 23;
    localparam int TOTAL_W  = 26;
    localparam int TARGET_W = 25;
    localparam int THRESH_W = 20;
    localparam int OP_W     = 3;
    localparam int MODE_W   = 3;

    localparam logic [OP_W-1:0] OP_MEAS  = 3'd0;
    localparam logic [OP_W-1:0] OP_START = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
    localparam logic [OP_W-1:0] OP_END   = 3'd3;
    localparam logic [OP_W-1:0] OP_INIT  = 3'd4;

    localparam logic [MODE_W-1:0] M_INIT      = 3'd0;
    localparam logic [MODE_W-1:0] M_IDLE      = 3'd1;
    localparam logic [MODE_W-1:0] M_CHARGING  = 3'd2;
    localparam logic [MODE_W-1:0] M_BALANCING = 3'd3;
    localparam logic [MODE_W-1:0] M_COMPLETE  = 3'd4;
    localparam logic [MODE_W-1:0] M_SLEEP     = 3'd5;
    localparam logic [MODE_W-1:0] M_ERROR     = 3'd6;

    localparam logic CFG_TARGET = 1'b0;
    localparam logic CFG_THRESH = 1'b1;

    typedef logic [CELL_W-1:0] t_cell;
    typedef t_cell [CELLS-1:0] t_cell_vec;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [CELL_W-1:0]  spread;
        logic [CELLS-1:0]   over_mask;
    } t_stats;

    typedef struct packed {
        logic [MODE_W-1:0]  charge_state;
        logic               contactor_on;
        logic [CELLS-1:0]   bleed_mask;
        logic [TOTAL_W-1:0] pack_total_uv;
        logic [CELL_W-1:0]  cell_spread_uv;
        logic               rejected;
    } t_result;

endpackage

/* src/cbc_if.sv */
interface cbc_req_if;
    import cbc_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic              ok;
    logic [CELL_W-1:0] cell_0;
    logic [CELL_W-1:0] cell_1;
    logic [CELL_W-1:0] cell_2;
    logic [CELL_W-1:0] cell_3;
    logic [CELL_W-1:0] cell_4;
    logic [CELL_W-1:0] cell_5;

    modport source (
        output valid, op, ok, cell_0, cell_1, cell_2, cell_3, cell_4, cell_5,
        input  ready
    );
    modport sink (
        input  valid, op, ok, cell_0, cell_1, cell_2, cell_3, cell_4, cell_5,
        output ready
    );
endinterface

interface cbc_rsp_if;
    import cbc_pkg::*;
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  charge_state;
    logic               contactor_on;
    logic [CELLS-1:0]   bleed_mask;
    logic [TOTAL_W-1:0] pack_total_uv;
    logic [CELL_W-1:0]  cell_spread_uv;
    logic               rejected;

    modport source (
        output valid, charge_state, contactor_on, bleed_mask, pack_total_uv,
               cell_spread_uv, rejected,
        input  ready
    );
    modport sink (
        input  valid, charge_state, contactor_on, bleed_mask, pack_total_uv,
               cell_spread_uv, rejected,
        output ready
    );
endinterface

/* src/cbc_stats.sv */
module cbc_stats
    import cbc_pkg::*;
(
    input  t_cell_vec             i_cell,
    input  logic [THRESH_W-1:0]   i_thresh,
    output t_stats                o_stats
);

    logic [TOTAL_W-1:0] sum;
    t_cell              mn;
    t_cell              mx;
    t_cell              diff;
    logic [CELLS-1:0]   mask;

    always_comb begin
        sum = '0;
        mn  = i_cell[0];
        mx  = i_cell[0];
        for (int i = 0; i < CELLS; i++) begin
            sum = sum + TOTAL_W'(i_cell[i]);
            if (i_cell[i] < mn) begin
                mn = i_cell[i];
            end
            if (i_cell[i] > mx) begin
                mx = i_cell[i];
            end
        end
    end

    always_comb begin
        mask = '0;
        diff = '0;
        for (int i = 0; i < CELLS; i++) begin
            diff    = i_cell[i] - mn;
            mask[i] = diff > CELL_W'(i_thresh);
        end
    end

    assign o_stats.total     = sum;
    assign o_stats.spread    = mx - mn;
    assign o_stats.over_mask = mask;

endmodule

/* src/cbc_seq.sv */
module cbc_seq
    import cbc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic [OP_W-1:0]     i_op,
    input  logic                i_ok,
    input  t_stats              i_stats,
    input  logic [TARGET_W-1:0] i_target,
    input  logic [THRESH_W-1:0] i_thresh,
    output t_result             o_result
);

    logic [MODE_W-1:0] r_mode;
    logic [MODE_W-1:0] n_mode;
    logic              r_contactor;
    logic              n_contactor;
    logic [CELLS-1:0]  r_bleed;
    logic [CELLS-1:0]  n_bleed;
    logic              r_hw_ready;
    logic              n_hw_ready;
    logic              rejected;
    logic              at_target;
    logic              wide_spread;
    logic              active;

    assign at_target   = i_stats.total >= TOTAL_W'(i_target);
    assign wide_spread = i_stats.spread > CELL_W'(i_thresh);
    assign active      = r_hw_ready && (r_mode == M_CHARGING || r_mode == M_BALANCING);

    always_comb begin
        n_mode      = r_mode;
        n_contactor = r_contactor;
        n_bleed     = r_bleed;
        n_hw_ready  = r_hw_ready;
        rejected    = 1'b0;
        unique case (i_op)
            OP_MEAS: begin
                if (active) begin
                    if (!i_ok) begin
                        n_mode      = M_ERROR;
                        n_contactor = 1'b0;
                    end else if (r_mode == M_CHARGING) begin
                        if (at_target) begin
                            n_contactor = 1'b0;
                            if (wide_spread) begin
                                n_mode  = M_BALANCING;
                                n_bleed = i_stats.over_mask;
                            end else begin
                                n_mode  = M_COMPLETE;
                                n_bleed = '0;
                            end
                        end
                    end else if (!wide_spread) begin
                        n_bleed = '0;
                        if (!at_target) begin
                            n_mode      = M_CHARGING;
                            n_contactor = 1'b1;
                        end else begin
                            n_mode = M_COMPLETE;
                        end
                    end
                end
            end
            OP_START: begin
                if (r_hw_ready && (r_mode == M_IDLE || r_mode == M_COMPLETE)) begin
                    n_mode      = M_CHARGING;
                    n_contactor = 1'b1;
                end else begin
                    rejected = 1'b1;
                end
            end
            OP_STOP: begin
                n_contactor = 1'b0;
                n_bleed     = '0;
                n_mode      = M_IDLE;
            end
            OP_END: begin
                if (r_hw_ready) begin
                    n_contactor = 1'b0;
                    n_bleed     = '0;
                    n_mode      = i_ok ? M_SLEEP : M_ERROR;
                end else begin
                    rejected = 1'b1;
                end
            end
            OP_INIT: begin
                if (r_mode == M_INIT && !r_hw_ready) begin
                    if (i_ok) begin
                        n_hw_ready = 1'b1;
                        n_mode     = M_IDLE;
                    end else begin
                        n_mode = M_ERROR;
                    end
                end else begin
                    rejected = 1'b1;
                end
            end
            default: begin
                rejected = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_INIT;
            r_contactor <= 1'b0;
            r_bleed     <= '0;
            r_hw_ready  <= 1'b0;
        end else if (i_adv) begin
            r_mode      <= n_mode;
            r_contactor <= n_contactor;
            r_bleed     <= n_bleed;
            r_hw_ready  <= n_hw_ready;
        end
    end

    always_comb begin
        o_result.charge_state   = n_mode;
        o_result.contactor_on   = n_contactor;
        o_result.bleed_mask     = n_bleed;
        o_result.rejected       = rejected;
        o_result.pack_total_uv  = '0;
        o_result.cell_spread_uv = '0;
        if (i_op == OP_MEAS && i_ok) begin
            o_result.pack_total_uv  = i_stats.total;
            o_result.cell_spread_uv = i_stats.spread;
        end
    end

endmodule

/* src/charge_balance_controller.sv */
// Charge and balance sequencer, one request or measurement per cycle while
// the response side is ready. A request passes an input register, then a
// result register after one pass of cell statistics and mode update.
// A stalled result register holds the input register, and i_req.ready
// follows o_rsp.ready in the same cycle while both registers are full. Reset
// (synchronous, active low) sets mode init, contactor open, no bleed, not
// initialized, and config to defaults.
module charge_balance_controller
    import cbc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    cbc_req_if.sink             i_req,
    cbc_rsp_if.source           o_rsp,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [TARGET_W-1:0] i_cfg_data
);

    logic [TARGET_W-1:0] r_target;
    logic [THRESH_W-1:0] r_thresh;

    logic              r_s1_valid;
    logic [OP_W-1:0]   r_s1_op;
    logic              r_s1_ok;
    t_cell_vec         r_s1_cell;

    logic              r_out_valid;
    t_result           r_out;

    logic              s2_take;
    logic              s1_load;
    t_stats            stats;
    t_result           result;

    assign s2_take     = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s2_take;
    assign s1_load     = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_W'(21000000);
            r_thresh <= THRESH_W'(10000);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TARGET: r_target <= i_cfg_data;
                CFG_THRESH: r_thresh <= i_cfg_data[THRESH_W-1:0];
                default:    r_target <= r_target;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_op      <= i_req.op;
            r_s1_ok      <= i_req.ok;
            r_s1_cell[0] <= i_req.cell_0;
            r_s1_cell[1] <= i_req.cell_1;
            r_s1_cell[2] <= i_req.cell_2;
            r_s1_cell[3] <= i_req.cell_3;
            r_s1_cell[4] <= i_req.cell_4;
            r_s1_cell[5] <= i_req.cell_5;
        end
    end

    cbc_stats u_stats (
        .i_cell   (r_s1_cell),
        .i_thresh (r_thresh),
        .o_stats  (stats)
    );

    cbc_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (s2_take),
        .i_op     (r_s1_op),
        .i_ok     (r_s1_ok),
        .i_stats  (stats),
        .i_target (r_target),
        .i_thresh (r_thresh),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_take) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_take) begin
            r_out <= result;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.charge_state   = r_out.charge_state;
    assign o_rsp.contactor_on   = r_out.contactor_on;
    assign o_rsp.bleed_mask     = r_out.bleed_mask;
    assign o_rsp.pack_total_uv  = r_out.pack_total_uv;
    assign o_rsp.cell_spread_uv = r_out.cell_spread_uv;
    assign o_rsp.rejected       = r_out.rejected;

endmodule
